[hw/rtl/deq_pkg.sv]
// Shared types and codes for the double-ended queue.
package deq_pkg;

   localparam int unsigned WORD_W = 32;
   localparam int unsigned OP_W = 3;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned TOTAL_W = 5;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic [OP_W-1:0] op_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam op_type OP_PUSH_FRONT = 3'd0;
   localparam op_type OP_PUSH_BACK = 3'd1;
   localparam op_type OP_POP_FRONT = 3'd2;
   localparam op_type OP_POP_BACK = 3'd3;
   localparam op_type OP_QUERY = 3'd4;

   localparam status_type STATUS_DONE = 2'd0;
   localparam status_type STATUS_FULL = 2'd1;
   localparam status_type STATUS_EMPTY = 2'd2;

   typedef logic [2:0] cell_op_type;

   localparam cell_op_type CELL_HOLD = 3'd0;
   localparam cell_op_type CELL_SHIFT_IN = 3'd1;
   localparam cell_op_type CELL_APPEND = 3'd2;
   localparam cell_op_type CELL_SHIFT_OUT = 3'd3;
   localparam cell_op_type CELL_TRIM = 3'd4;

   typedef struct packed {
      cell_op_type code;
      word_type data;
   } chain_cmd_type;

endpackage

[hw/rtl/deq_cell.sv]
// One storage cell of the queue chain: an entry and its valid bit.
module deq_cell
   import deq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  chain_cmd_type cmd,
   input  logic          left_valid,
   input  word_type      left_data,
   input  logic          right_valid,
   input  word_type      right_data,
   output logic          valid,
   output word_type      data,
   output word_type      data_next
);

   logic     valid_ff;
   logic     valid_in;
   word_type data_ff;
   word_type data_in;

   always_comb begin
      valid_in = valid_ff;
      data_in = data_ff;
      unique case (cmd.code)
         CELL_SHIFT_IN: begin
            valid_in = left_valid;
            data_in = left_data;
         end
         CELL_APPEND: begin
            if (!valid_ff && left_valid) begin
               valid_in = 1'b1;
               data_in = cmd.data;
            end
         end
         CELL_SHIFT_OUT: begin
            valid_in = right_valid;
            data_in = right_data;
         end
         CELL_TRIM: begin
            if (valid_ff && !right_valid) begin
               valid_in = 1'b0;
            end
         end
         default: begin
            valid_in = valid_ff;
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign valid = valid_ff;
   assign data = data_ff;
   assign data_next = data_in;

endmodule

[hw/rtl/deq_chain.sv]
// Row of queue cells with its head at cell zero.
module deq_chain
   import deq_pkg::*;
#(
   parameter int unsigned DEPTH = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  chain_cmd_type cmd,
   output logic          head_valid,
   output word_type      head_next
);

   logic     valid_w [DEPTH];
   word_type data_w [DEPTH];
   word_type next_w [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic     lv;
      word_type ld;
      logic     rv;
      word_type rd;

      if (i == 0) begin : g_head
         assign lv = 1'b1;
         assign ld = cmd.data;
      end else begin : g_body
         assign lv = valid_w[i-1];
         assign ld = data_w[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign rv = 1'b0;
         assign rd = '0;
      end else begin : g_inner
         assign rv = valid_w[i+1];
         assign rd = data_w[i+1];
      end

      deq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .left_valid  (lv),
         .left_data   (ld),
         .right_valid (rv),
         .right_data  (rd),
         .valid       (valid_w[i]),
         .data        (data_w[i]),
         .data_next   (next_w[i])
      );
   end

   assign head_valid = valid_w[0];
   assign head_next = next_w[0];

endmodule

[hw/rtl/double_ended_queue.sv]
// Top level of the bounded double-ended queue of signed 32-bit values.
//
//   Channel  Direction  Handshake              Payload
//   req_     in         req_valid/req_ready    operation, data_value
//   rsp_     out        rsp_valid/rsp_ready    front_value, back_value, entry_total, status
//
// One transaction per cycle while no response is stalled; its response appears in the cycle after acceptance.
// Two mirrored cell chains hold the entries, one headed by the front and one by
// the back, so every push or pop is a one-step shift, append or trim in each chain.
// Reset clears the valid bits and the count; entries stay unknown.
// req_ready drops only while a response waits on a stalled rsp_ready.
module double_ended_queue
   import deq_pkg::*;
#(
   parameter int unsigned DEPTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [OP_W-1:0]            req_operation,
   input  logic signed [WORD_W-1:0]   req_data_value,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [WORD_W-1:0]   rsp_front_value,
   output logic signed [WORD_W-1:0]   rsp_back_value,
   output logic [TOTAL_W-1:0]         rsp_entry_total,
   output logic [STATUS_W-1:0]        rsp_status
);

   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   logic          accept;
   logic          full;
   logic          empty;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   status_type    status_in;
   chain_cmd_type front_cmd;
   chain_cmd_type back_cmd;
   logic          front_head_valid;
   logic          back_head_valid;
   word_type      front_head_next;
   word_type      back_head_next;
   logic [31:0]   total_wide;

   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   word_type      rsp_front_ff;
   word_type      rsp_back_ff;
   logic [TOTAL_W-1:0] rsp_total_ff;
   status_type    rsp_status_ff;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept = req_valid && req_ready;
   assign full = (count_ff == FULL_COUNT);
   assign empty = (count_ff == '0);

   always_comb begin
      count_in = count_ff;
      status_in = STATUS_DONE;
      front_cmd.code = CELL_HOLD;
      front_cmd.data = req_data_value;
      back_cmd.code = CELL_HOLD;
      back_cmd.data = req_data_value;
      if (accept) begin
         unique case (req_operation)
            OP_PUSH_FRONT: begin
               if (full) begin
                  status_in = STATUS_FULL;
               end else begin
                  front_cmd.code = CELL_SHIFT_IN;
                  back_cmd.code = CELL_APPEND;
                  count_in = count_ff + 1'b1;
               end
            end
            OP_PUSH_BACK: begin
               if (full) begin
                  status_in = STATUS_FULL;
               end else begin
                  front_cmd.code = CELL_APPEND;
                  back_cmd.code = CELL_SHIFT_IN;
                  count_in = count_ff + 1'b1;
               end
            end
            OP_POP_FRONT: begin
               if (empty) begin
                  status_in = STATUS_EMPTY;
               end else begin
                  front_cmd.code = CELL_SHIFT_OUT;
                  back_cmd.code = CELL_TRIM;
                  count_in = count_ff - 1'b1;
               end
            end
            OP_POP_BACK: begin
               if (empty) begin
                  status_in = STATUS_EMPTY;
               end else begin
                  front_cmd.code = CELL_TRIM;
                  back_cmd.code = CELL_SHIFT_OUT;
                  count_in = count_ff - 1'b1;
               end
            end
            default: begin
               status_in = STATUS_DONE;
            end
         endcase
      end
   end

   deq_chain #(.DEPTH(DEPTH)) u_front_chain (
      .clock      (clock),
      .reset      (reset),
      .cmd        (front_cmd),
      .head_valid (front_head_valid),
      .head_next  (front_head_next)
   );

   deq_chain #(.DEPTH(DEPTH)) u_back_chain (
      .clock      (clock),
      .reset      (reset),
      .cmd        (back_cmd),
      .head_valid (back_head_valid),
      .head_next  (back_head_next)
   );

   assign total_wide = 32'(count_in);

   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_front_ff <= (count_in == '0) ? '0 : front_head_next;
         rsp_back_ff <= (count_in == '0) ? '0 : back_head_next;
         rsp_total_ff <= total_wide[TOTAL_W-1:0];
         rsp_status_ff <= status_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_front_value = rsp_front_ff;
   assign rsp_back_value = rsp_back_ff;
   assign rsp_entry_total = rsp_total_ff;
   assign rsp_status = rsp_status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count above depth");

   a_front_head: assert property (@(posedge clock) disable iff (reset)
      front_head_valid == !empty)
      else $error("front chain head disagrees with count");

   a_back_head: assert property (@(posedge clock) disable iff (reset)
      back_head_valid == !empty)
      else $error("back chain head disagrees with count");

   a_refused_hold: assert property (@(posedge clock) disable iff (reset)
      accept && status_in != STATUS_DONE |=> count_ff == $past(count_ff))
      else $error("refused transaction changed the count");

   a_stall_block: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !req_ready)
      else $error("request taken while response stalled");

endmodule
